### rtl/wtq_pkg.sv
// Package for the wraparound timer queue: sizes, request and status codes,
// and the modular time compare. No dependencies.
package wtq_pkg;
	localparam int DEPTH     = 16;
	localparam int TIME_BITS = 16;
	localparam int ID_BITS   = 4;
	localparam int AW        = $clog2(DEPTH);
	localparam int CW        = $clog2(DEPTH + 1);

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_EXPIRE = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOT_DUE  = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [TIME_BITS-1:0] wake;
		logic [ID_BITS-1:0]   id;
	} entry_t;

	// a is equal to or later than b, modulo 2^TIME_BITS
	function automatic logic not_before(input logic [TIME_BITS-1:0] a,
		input logic [TIME_BITS-1:0] b);
		logic [TIME_BITS-1:0] d;
		d = a - b;
		return ~d[TIME_BITS-1];
	endfunction
endpackage

### rtl/wraparound_timer_queue.sv
// Top level of the wraparound timer queue: one entry memory plus the
// sequencer that scans and shifts it. Depends on wtq_pkg.
//
// Usage: raise start with action, task_id and stamp while busy is low; the
// request is taken at that edge and busy stays high until the result has
// been shown. The result (status, popped_id, occupancy) is valid for exactly
// one cycle while result_valid is high; the receiver cannot stall it.
// Actions: insert keeps the entries in deadline order (modular compare,
// a new entry goes ahead of equal times), expire pops the head when its
// deadline is due at stamp, remove takes out the entry nearest the head
// with the given id. Action code 3 is ignored with status done.
// Sequencing: every step works through the entry memory, whose read data
// arrives in the cycle after the address. A scan reads and then compares
// each entry visited and a shift reads and then writes each entry moved;
// the shortest requests are the trivial ones that go straight to the result.
// occupancy always shows the entry count after the last request.
// Reset: arst_n clears the count and the sequencer; memory contents are
// never read before being written, so no clearing pass is needed.
module wraparound_timer_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [1:0]                    action,
	input  logic [wtq_pkg::ID_BITS-1:0]   task_id,
	input  logic [wtq_pkg::TIME_BITS-1:0] stamp,
	output logic                          busy,
	output logic                          result_valid,
	output logic [1:0]                    status,
	output logic [wtq_pkg::ID_BITS-1:0]   popped_id,
	output logic [wtq_pkg::CW-1:0]        occupancy
);
	import wtq_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1; // read entry under scan
	localparam logic [2:0] S_CHK  = 3'd2; // compare scanned entry
	localparam logic [2:0] S_DRD  = 3'd3; // downward shift: read j-1
	localparam logic [2:0] S_DWR  = 3'd4; // downward shift: write j
	localparam logic [2:0] S_URD  = 3'd5; // upward shift: read j
	localparam logic [2:0] S_UWR  = 3'd6; // upward shift: write j-1
	localparam logic [2:0] S_RESP = 3'd7;

	logic [2:0]           state_q;
	logic [1:0]           act_q;
	logic [ID_BITS-1:0]   id_q;
	logic [TIME_BITS-1:0] stamp_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;   // scan index
	logic [CW-1:0]        pos_q;   // insert slot
	logic [CW-1:0]        j_q;     // shift index
	logic [1:0]           status_q;
	logic [ID_BITS-1:0]   popped_q;

	// entry memory, registered read data
	entry_t mem [DEPTH];
	entry_t rdata_q;
	logic   re, we;
	logic [AW-1:0] raddr, waddr;
	entry_t wdata;

	logic [CW-1:0] idx_nx, jm1, jp1;
	assign idx_nx = idx_q + 1'b1;
	assign jm1    = j_q - 1'b1;
	assign jp1    = j_q + 1'b1;

	always_comb begin
		re    = 1'b0;
		we    = 1'b0;
		raddr = idx_q[AW-1:0];
		waddr = j_q[AW-1:0];
		wdata = rdata_q;
		unique case (state_q)
			S_RD: begin
				re = 1'b1;
			end
			S_DRD: begin
				if (j_q == pos_q) begin
					// slot is open: place the new entry
					we    = 1'b1;
					waddr = pos_q[AW-1:0];
					wdata = '{wake: stamp_q, id: id_q};
				end else begin
					re    = 1'b1;
					raddr = jm1[AW-1:0];
				end
			end
			S_DWR: begin
				we = 1'b1;
			end
			S_URD: begin
				re    = (j_q != count_q);
				raddr = j_q[AW-1:0];
			end
			S_UWR: begin
				we    = 1'b1;
				waddr = jm1[AW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			pos_q    <= '0;
			j_q      <= '0;
			act_q    <= '0;
			id_q     <= '0;
			stamp_q  <= '0;
			status_q <= ST_DONE;
			popped_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q    <= action;
						id_q     <= task_id;
						stamp_q  <= stamp;
						status_q <= ST_DONE;
						popped_q <= '0;
						idx_q    <= '0;
						priority if (action == ACT_INSERT) begin
							if (count_q == CW'(DEPTH)) begin
								status_q <= ST_FULL;
								state_q  <= S_RESP;
							end else if (count_q == '0) begin
								pos_q   <= '0;
								j_q     <= '0;
								state_q <= S_DRD;
							end else begin
								state_q <= S_RD;
							end
						end else if (action == ACT_EXPIRE) begin
							if (count_q == '0) begin
								status_q <= ST_NOT_DUE;
								state_q  <= S_RESP;
							end else begin
								state_q <= S_RD;
							end
						end else if (action == ACT_REMOVE) begin
							if (count_q == '0) begin
								status_q <= ST_NOT_FOUND;
								state_q  <= S_RESP;
							end else begin
								state_q <= S_RD;
							end
						end else begin
							// unused code: report done, queue untouched
							state_q <= S_RESP;
						end
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					priority if (act_q == ACT_INSERT) begin
						if (not_before(rdata_q.wake, stamp_q)) begin
							pos_q   <= idx_q;
							j_q     <= count_q;
							state_q <= S_DRD;
						end else if (idx_nx == count_q) begin
							// later than all: append at the tail
							pos_q   <= count_q;
							j_q     <= count_q;
							state_q <= S_DRD;
						end else begin
							idx_q   <= idx_nx;
							state_q <= S_RD;
						end
					end else if (act_q == ACT_EXPIRE) begin
						if (not_before(stamp_q, rdata_q.wake)) begin
							popped_q <= rdata_q.id;
							j_q      <= CW'(1);
							state_q  <= S_URD;
						end else begin
							status_q <= ST_NOT_DUE;
							state_q  <= S_RESP;
						end
					end else begin
						if (rdata_q.id == id_q) begin
							popped_q <= rdata_q.id;
							j_q      <= idx_nx;
							state_q  <= S_URD;
						end else if (idx_nx == count_q) begin
							status_q <= ST_NOT_FOUND;
							state_q  <= S_RESP;
						end else begin
							idx_q   <= idx_nx;
							state_q <= S_RD;
						end
					end
				end
				S_DRD: begin
					if (j_q == pos_q) begin
						count_q <= count_q + 1'b1;
						state_q <= S_RESP;
					end else begin
						state_q <= S_DWR;
					end
				end
				S_DWR: begin
					j_q     <= jm1;
					state_q <= S_DRD;
				end
				S_URD: begin
					if (j_q == count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_RESP;
					end else begin
						state_q <= S_UWR;
					end
				end
				S_UWR: begin
					j_q     <= jp1;
					state_q <= S_URD;
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = (state_q == S_RESP);
	assign status       = status_q;
	assign popped_id    = popped_q;
	assign occupancy    = count_q;

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken but sequencer idle");
	a_popped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != ST_DONE) |-> (popped_id == '0))
		else $error("id reported on failed request");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_DRD && state_q != S_URD) |=> $stable(count_q))
		else $error("count moved outside a shift end");
endmodule
